@@ rtl/tefp_pkg.sv @@
// ----------------------------------------------------------------------------
// tefp_pkg
// Shared types and constants of the tensor element to binary32 converter.
// ----------------------------------------------------------------------------
package tefp_pkg;

	typedef enum logic [3:0] {
		FMT_F64  = 4'd0,
		FMT_F32  = 4'd1,
		FMT_F16  = 4'd2,
		FMT_BF16 = 4'd3,
		FMT_E4M3 = 4'd4,
		FMT_E5M2 = 4'd5,
		FMT_I64  = 4'd6,
		FMT_I32  = 4'd7,
		FMT_I16  = 4'd8,
		FMT_I8   = 4'd9,
		FMT_U8   = 4'd10,
		FMT_BOOL = 4'd11,
		FMT_NONE = 4'd12
	} fmt_t;

	localparam logic [3:0]  FMT_RESET = 4'd1;
	localparam logic [31:0] F32_INF   = 32'h7F80_0000;
	localparam logic [31:0] F32_QNAN  = 32'h7FC0_0000;
	localparam logic [31:0] F32_ZERO  = 32'h0000_0000;

	typedef struct packed {
		logic [63:0] raw_element;
		logic        last_element;
	} in_beat_t;

	typedef struct packed {
		logic [31:0] fp32_bits;
		logic        last_out;
	} out_beat_t;

	// Decoded element: value is mag scaled so that the biased binary32
	// exponent equals bexp + msb_index + 1.
	typedef struct packed {
		logic               special;
		logic [31:0]        spec_bits;
		logic               sign;
		logic [63:0]        mag;
		logic signed [12:0] bexp;
		logic               last;
	} dec_t;

	typedef struct packed {
		logic               special;
		logic [31:0]        spec_bits;
		logic               sign;
		logic               zero;
		logic [63:0]        mag;
		logic [5:0]         msb;
		logic signed [12:0] eb;
		logic               last;
	} norm_t;

	typedef struct packed {
		logic               special;
		logic [31:0]        spec_bits;
		logic               sign;
		logic               zero;
		logic               normal;
		logic signed [12:0] ebm1;
		logic [23:0]        q;
		logic               guard;
		logic               sticky;
		logic               last;
	} shf_t;

endpackage

@@ rtl/tefp_decode.sv @@
// ----------------------------------------------------------------------------
// tefp_decode
// Reads a raw element in the selected format into sign, magnitude and exponent.
// ----------------------------------------------------------------------------
module tefp_decode (
	input  logic [3:0]         fmt,
	input  tefp_pkg::in_beat_t beat,
	output tefp_pkg::dec_t     dec
);

	logic [63:0] raw;
	logic [10:0] ex64;
	logic [15:0] h;
	logic [4:0]  ex16;
	logic [3:0]  ex8;
	logic [63:0] sx;

	always_comb begin
		raw  = beat.raw_element;
		ex64 = raw[62:52];
		h    = (fmt == tefp_pkg::FMT_E5M2) ? {raw[7:0], 8'd0} : raw[15:0];
		ex16 = h[14:10];
		ex8  = raw[6:3];
		sx   = raw;
		dec  = '0;
		dec.last = beat.last_element;
		case (fmt)
			tefp_pkg::FMT_F64: begin
				dec.sign = raw[63];
				if (ex64 == 11'h7FF) begin
					dec.special = 1'b1;
					dec.spec_bits = (raw[51:0] == 52'd0) ?
						({raw[63], 31'd0} | tefp_pkg::F32_INF) :
						({raw[63], 31'd0} | tefp_pkg::F32_QNAN | {9'd0, raw[51:29]});
				end else if (ex64 == 11'd0) begin
					dec.special = 1'b1;
					dec.spec_bits = {raw[63], 31'd0};
				end else begin
					dec.mag = {12'd1, raw[51:0]};
					dec.bexp = $signed({2'b00, ex64}) - 13'sd949;
				end
			end
			tefp_pkg::FMT_F32: begin
				dec.special = 1'b1;
				dec.spec_bits = raw[31:0];
			end
			tefp_pkg::FMT_BF16: begin
				dec.special = 1'b1;
				dec.spec_bits = {raw[15:0], 16'd0};
			end
			tefp_pkg::FMT_F16, tefp_pkg::FMT_E5M2: begin
				dec.sign = h[15];
				if (ex16 == 5'd31) begin
					dec.special = 1'b1;
					dec.spec_bits = (h[9:0] == 10'd0) ?
						({h[15], 31'd0} | tefp_pkg::F32_INF) :
						({h[15], 31'd0} | tefp_pkg::F32_QNAN | {9'd0, h[9:0], 13'd0});
				end else if (ex16 == 5'd0) begin
					dec.mag = {54'd0, h[9:0]};
					dec.bexp = 13'sd102;
				end else begin
					dec.mag = {53'd0, 1'b1, h[9:0]};
					dec.bexp = $signed({8'd0, ex16}) + 13'sd101;
				end
			end
			tefp_pkg::FMT_E4M3: begin
				dec.sign = raw[7];
				if (ex8 == 4'd15 && raw[2:0] == 3'd7) begin
					dec.special = 1'b1;
					dec.spec_bits = {raw[7], 31'd0} | tefp_pkg::F32_QNAN;
				end else if (ex8 == 4'd0) begin
					dec.mag = {61'd0, raw[2:0]};
					dec.bexp = 13'sd117;
				end else begin
					dec.mag = {60'd0, 1'b1, raw[2:0]};
					dec.bexp = $signed({9'd0, ex8}) + 13'sd116;
				end
			end
			tefp_pkg::FMT_I64, tefp_pkg::FMT_I32, tefp_pkg::FMT_I16,
			tefp_pkg::FMT_I8: begin
				if (fmt == tefp_pkg::FMT_I32) sx = {{32{raw[31]}}, raw[31:0]};
				else if (fmt == tefp_pkg::FMT_I16) sx = {{48{raw[15]}}, raw[15:0]};
				else if (fmt == tefp_pkg::FMT_I8) sx = {{56{raw[7]}}, raw[7:0]};
				dec.sign = sx[63];
				dec.mag = sx[63] ? (~sx + 64'd1) : sx;
				dec.bexp = 13'sd126;
			end
			tefp_pkg::FMT_U8, tefp_pkg::FMT_BOOL: begin
				dec.mag = {56'd0, raw[7:0]};
				dec.bexp = 13'sd126;
			end
			default: begin
				dec.special = 1'b1;
				dec.spec_bits = tefp_pkg::F32_ZERO;
			end
		endcase
	end

endmodule

@@ rtl/tefp_lzc.sv @@
// ----------------------------------------------------------------------------
// tefp_lzc
// Finds the leading one of the magnitude and forms the result exponent.
// ----------------------------------------------------------------------------
module tefp_lzc (
	input  tefp_pkg::dec_t  dec,
	output tefp_pkg::norm_t nrm
);

	logic [5:0] msb;

	always_comb begin
		msb = 6'd0;
		for (int i = 0; i < 64; i++) begin
			if (dec.mag[i]) msb = 6'(i);
		end
		nrm.special   = dec.special;
		nrm.spec_bits = dec.spec_bits;
		nrm.sign      = dec.sign;
		nrm.zero      = (dec.mag == 64'd0);
		nrm.mag       = dec.mag;
		nrm.msb       = msb;
		nrm.eb        = dec.bexp + $signed({7'd0, msb}) + 13'sd1;
		nrm.last      = dec.last;
	end

endmodule

@@ rtl/tefp_shift.sv @@
// ----------------------------------------------------------------------------
// tefp_shift
// Aligns the magnitude to the binary32 significand and collects round bits.
// ----------------------------------------------------------------------------
module tefp_shift (
	input  tefp_pkg::norm_t nrm,
	output tefp_pkg::shf_t  shf
);

	logic               normal;
	logic signed [12:0] rs;
	logic               left;
	logic               big;
	logic [4:0]         lamt;
	logic [6:0]         ramt;
	logic [6:0]         gidx;
	logic [63:0]        lsh;
	logic [63:0]        rsh;
	logic [63:0]        lowmask;

	always_comb begin
		normal  = (nrm.eb > 13'sd0);
		rs      = normal ? ($signed({7'd0, nrm.msb}) - 13'sd23) :
			($signed({7'd0, nrm.msb}) - 13'sd22 - nrm.eb);
		left    = (rs < 13'sd0);
		big     = (rs >= 13'sd64);
		lamt    = 5'(-rs);
		ramt    = (left || big) ? 7'd0 : rs[6:0];
		gidx    = (ramt == 7'd0) ? 7'd0 : (ramt - 7'd1);
		lsh     = nrm.mag << lamt;
		rsh     = nrm.mag >> ramt;
		lowmask = (64'd1 << gidx) - 64'd1;

		shf.special   = nrm.special;
		shf.spec_bits = nrm.spec_bits;
		shf.sign      = nrm.sign;
		shf.zero      = nrm.zero;
		shf.normal    = normal;
		shf.ebm1      = nrm.eb - 13'sd1;
		shf.q         = left ? lsh[23:0] : (big ? 24'd0 : rsh[23:0]);
		shf.guard     = !left && !big && (ramt != 7'd0) && nrm.mag[gidx[5:0]];
		shf.sticky    = !left && !big && (ramt > 7'd1) && ((nrm.mag & lowmask) != 64'd0);
		shf.last      = nrm.last;
	end

endmodule

@@ rtl/tensor_element_to_fp32_core.sv @@
// ----------------------------------------------------------------------------
// tensor_element_to_fp32_core
// Converts one tensor element per beat from a configured format to binary32.
// ----------------------------------------------------------------------------
// The element channel (elem_valid, elem_ready, elem) carries a raw element,
// right aligned in 64 bits, and a last flag. The result channel (res_valid,
// res_ready, res) returns the binary32 bit pattern and the copied last flag,
// one result beat for each element beat, in order.
// cfg_we writes cfg_wdata into the source format register; write it only
// while no beat is in flight. Reset selects f32 and empties the pipeline.
// The pipeline has four register stages: decode, leading-one search and
// exponent, alignment shift, then rounding and packing into the result
// register. One beat is accepted in every cycle while the receiver takes
// results.
// When res_ready is low with a result waiting, the whole pipeline holds and
// elem_ready drops in the same cycle; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module tensor_element_to_fp32_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [3:0]            cfg_wdata,
	input  logic                  elem_valid,
	output logic                  elem_ready,
	input  tefp_pkg::in_beat_t    elem,
	output logic                  res_valid,
	input  logic                  res_ready,
	output tefp_pkg::out_beat_t   res
);

	logic [3:0]           fmt_q;
	logic                 adv;
	logic                 v_s1, v_s2, v_s3, v_s4;
	tefp_pkg::dec_t       dec_c, dec_s1;
	tefp_pkg::norm_t      nrm_c, nrm_s2;
	tefp_pkg::shf_t       shf_c, shf_s3;
	tefp_pkg::out_beat_t  res_c, res_s4;
	logic [24:0]          r;
	logic [31:0]          sum;

	assign adv        = !v_s4 || res_ready;
	assign elem_ready = adv;
	assign res_valid  = v_s4;
	assign res        = res_s4;

	tefp_decode u_decode (.fmt(fmt_q), .beat(elem), .dec(dec_c));
	tefp_lzc    u_lzc    (.dec(dec_s1), .nrm(nrm_c));
	tefp_shift  u_shift  (.nrm(nrm_s2), .shf(shf_c));

	always_comb begin
		r = {1'b0, shf_s3.q} + {24'd0, shf_s3.guard && (shf_s3.sticky || shf_s3.q[0])};
		sum = {1'b0, shf_s3.ebm1[7:0], 23'd0} + {7'd0, r};
		res_c.last_out = shf_s3.last;
		if (shf_s3.special) begin
			res_c.fp32_bits = shf_s3.spec_bits;
		end else if (shf_s3.zero) begin
			res_c.fp32_bits = {shf_s3.sign, 31'd0};
		end else if (shf_s3.normal) begin
			if (shf_s3.ebm1 >= 13'sd255 || sum >= tefp_pkg::F32_INF) begin
				res_c.fp32_bits = {shf_s3.sign, 31'd0} | tefp_pkg::F32_INF;
			end else begin
				res_c.fp32_bits = {shf_s3.sign, sum[30:0]};
			end
		end else begin
			res_c.fp32_bits = {shf_s3.sign, 6'd0, r};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= tefp_pkg::FMT_RESET;
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
		end else begin
			if (cfg_we) fmt_q <= cfg_wdata;
			if (adv) begin
				v_s1 <= elem_valid;
				v_s2 <= v_s1;
				v_s3 <= v_s2;
				v_s4 <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dec_s1 <= dec_c;
			nrm_s2 <= nrm_c;
			shf_s3 <= shf_c;
			res_s4 <= res_c;
		end
	end

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s4 |-> elem_ready) else $error("pipeline stalls with no result waiting");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && !res_ready) |=> (v_s4 && $stable(res_s4)))
		else $error("waiting result lost or changed");

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(elem_valid && elem_ready) |=> v_s1) else $error("accepted beat not captured");

	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && adv) |=> v_s4) else $error("beat dropped between stages");

endmodule
